// ===== hdl/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat sender window package
// Shared types and constants for the window cells and the top level.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Field widths on the stream and configuration ports.
  localparam int OP_W      = 2;
  localparam int ACK_W     = 16;
  localparam int KIND_W    = 3;
  localparam int SEQ_W     = 16;
  localparam int FL_W      = 4;
  localparam int OUT_DW    = 40;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int TO_W      = 16;
  localparam int TIME_W    = 32;

  // Timeout after reset, in ticks.
  localparam logic [TO_W-1:0] TIMEOUT_RESET = 16'd1500;

  // Most retransmits that one tick may produce.
  localparam int MAX_RET = 8;
  localparam int NRET_W  = $clog2(MAX_RET);

  // Input operations.
  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NEW      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RETX     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_OK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACK_IGN  = 3'd4;

  // Configuration register index (taken from paddr[2]).
  localparam logic REG_TIMEOUT = 1'b0;

  // State of one window slot.
  typedef struct packed {
    logic              acked;
    logic              active;
    logic [TIME_W-1:0] start;
  } slot_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic load;
    logic ack;
    logic restart;
  } cell_ctrl_t;

endpackage

// ===== hdl/srsw_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one slot of the window and takes its upper neighbor's slot on a shift.
// ----------------------------------------------------------------------------
module srsw_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srsw_pkg::cell_ctrl_t       ctrl,
  input  srsw_pkg::slot_t            from_up,
  input  logic [srsw_pkg::TIME_W-1:0] now,
  input  logic [srsw_pkg::TO_W-1:0]   timeout,
  output srsw_pkg::slot_t            slot,
  output logic                       expired
);
  import srsw_pkg::*;

  logic              acked_r, acked_nxt;
  logic              active_r, active_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] elapsed;

  // Next slot state: a shift wins, the other controls never coincide with it.
  always_comb begin
    acked_nxt  = acked_r;
    active_nxt = active_r;
    start_nxt  = start_r;
    if (ctrl.shift) begin
      acked_nxt  = from_up.acked;
      active_nxt = from_up.active;
      start_nxt  = from_up.start;
    end else if (ctrl.load) begin
      acked_nxt  = 1'b0;
      active_nxt = 1'b1;
      start_nxt  = now;
    end else if (ctrl.ack) begin
      acked_nxt  = 1'b1;
      active_nxt = 1'b0;
    end else if (ctrl.restart) begin
      start_nxt  = now;
    end
  end

  // Flags are cleared at reset; the start time is written before it is used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      acked_r  <= acked_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  // Timer check, elapsed time taken modulo the counter width.
  assign elapsed = now - start_r;
  assign expired = active_r && !acked_r && (elapsed >= TIME_W'(timeout));

  assign slot.acked  = acked_r;
  assign slot.active = active_r;
  assign slot.start  = start_r;

endmodule

// ===== hdl/selective_repeat_sender_window.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat sender window
// Tracks outstanding sequence numbers, acknowledgements and retransmit timers.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one operation per transaction: in_tuser selects
//   send, acknowledge or tick, and in_tdata carries the acknowledged sequence
//   number. The out_ channel returns result transactions; out_tlast marks the
//   final result of an operation. A tick that resends nothing returns nothing.
//   The window is a row of cells ordered by offset from the base; the base
//   slides by shifting every cell one place down, one place per cycle.
//   Each operation is taken in IDLE and carried out in EXEC; an accepted ack
//   then slides the base in SLIDE past each acknowledged slot (at most
//   WINDOW), and a tick passes through EVAL and SCAN, which emits at most one
//   retransmit per cycle while the output is free. One operation is in work
//   at a time.
//   The output register lets an operation be accepted while a result waits;
//   when out_tready is low the block holds its result and stalls the work.
//   Reset empties the window, clears time and sets the timeout to 1500 ticks.
//   The timeout register is at byte address 0 of the cfg_ port.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [srsw_pkg::ACK_W-1:0]    in_tdata,    // [15:0] ack_seq
  input  logic [srsw_pkg::OP_W-1:0]     in_tuser,    // [1:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [srsw_pkg::OUT_DW-1:0]   out_tdata,   // [15:0] seq, [31:16] window_base,
                                                     // [35:32] in_flight, [39:36] zero
  output logic [srsw_pkg::KIND_W-1:0]   out_tuser,   // [2:0] kind
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [srsw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [srsw_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [srsw_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import srsw_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = $clog2(WINDOW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SLIDE = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SEQ_BITS-1:0] next_r, next_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [WINDOW-1:0]   ex_r, ex_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [NRET_W-1:0]   nret_r, nret_nxt;
  logic [TO_W-1:0]     timeout_r;
  logic [OP_W-1:0]     op_r;
  logic [SEQ_BITS-1:0] ack_r;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [SEQ_W-1:0]    out_seq_r;
  logic [SEQ_W-1:0]    out_base_r;
  logic [FL_W-1:0]     out_fl_r;
  logic                out_last_r;
  logic                out_free;

  logic                emit;
  logic [KIND_W-1:0]   e_kind;
  logic [SEQ_BITS-1:0] e_seq;
  logic [CW-1:0]       e_fl;
  logic                e_last;
  logic                do_shift, do_load, do_ack, do_restart;

  logic [SEQ_BITS-1:0] ack_off;
  logic [WINDOW-1:0]   ack_sel;
  logic [WINDOW-1:0]   acked_vec;
  logic [WINDOW-1:0]   ex_vec;
  logic                ack_hit;
  logic                cfg_wr;

  slot_t               cell_q  [WINDOW];
  slot_t               cell_up [WINDOW];
  cell_ctrl_t          cell_c  [WINDOW];
  logic [WINDOW-1:0]   cell_ex;

  // Configuration port: timeout register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TIMEOUT) ? CFG_DW'(timeout_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TIMEOUT) begin
      timeout_r <= cfg_pwdata[TO_W-1:0];
    end
  end

  // Row of window cells; cell i holds sequence number base + i.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i < WINDOW - 1) begin : g_mid
      assign cell_up[i] = cell_q[i+1];
    end else begin : g_top
      assign cell_up[i] = '0;
    end

    assign ack_sel[i]   = (ack_off == SEQ_BITS'(i));
    assign acked_vec[i] = cell_q[i].acked;
    assign ex_vec[i]    = cell_ex[i] && (CW'(i) < count_r);

    assign cell_c[i].shift   = do_shift;
    assign cell_c[i].load    = do_load && (count_r == CW'(i));
    assign cell_c[i].ack     = do_ack && ack_sel[i];
    assign cell_c[i].restart = do_restart && (pos_r == IW'(i));

    srsw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_c[i]),
      .from_up (cell_up[i]),
      .now     (now_r),
      .timeout (timeout_r),
      .slot    (cell_q[i]),
      .expired (cell_ex[i])
    );
  end

  // Acknowledgement lookup against the current window.
  assign ack_off = ack_r - base_r;
  assign ack_hit = (ack_off < SEQ_BITS'(count_r)) && (|(ack_sel & ~acked_vec));

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Sequencer for one operation at a time.
  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    count_nxt  = count_r;
    now_nxt    = now_r;
    ex_nxt     = ex_r;
    pos_nxt    = pos_r;
    nret_nxt   = nret_r;
    emit       = 1'b0;
    e_kind     = KIND_NEW;
    e_seq      = next_r;
    e_fl       = count_r;
    e_last     = 1'b1;
    do_shift   = 1'b0;
    do_load    = 1'b0;
    do_ack     = 1'b0;
    do_restart = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_SEND: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
              if (count_r >= CW'(WINDOW)) begin
                e_kind = KIND_REFUSED;
              end else begin
                do_load   = 1'b1;
                next_nxt  = next_r + 1'b1;
                count_nxt = count_r + 1'b1;
                e_fl      = count_nxt;
              end
            end
          end
          OP_ACK: begin
            if (ack_hit) begin
              do_ack    = 1'b1;
              state_nxt = ST_SLIDE;
            end else if (out_free) begin
              emit      = 1'b1;
              e_kind    = KIND_ACK_IGN;
              e_seq     = ack_r;
              state_nxt = ST_IDLE;
            end
          end
          OP_TICK: begin
            now_nxt   = now_r + 1'b1;
            state_nxt = ST_EVAL;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SLIDE: begin
        if (count_r != '0 && cell_q[0].acked) begin
          do_shift  = 1'b1;
          base_nxt  = base_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end else if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_ACK_OK;
          e_seq     = ack_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        ex_nxt    = ex_vec;
        pos_nxt   = '0;
        nret_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (ex_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!ex_r[0]) begin
          ex_nxt  = ex_r >> 1;
          pos_nxt = pos_r + 1'b1;
        end else if (out_free) begin
          emit       = 1'b1;
          do_restart = 1'b1;
          e_kind     = KIND_RETX;
          e_seq      = base_r + SEQ_BITS'(pos_r);
          e_last     = (nret_r == NRET_W'(MAX_RET - 1)) || ((ex_r >> 1) == '0);
          nret_nxt   = nret_r + 1'b1;
          if (e_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ex_nxt  = ex_r >> 1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      count_r     <= '0;
      now_r       <= '0;
      ex_r        <= '0;
      pos_r       <= '0;
      nret_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      count_r <= count_nxt;
      now_r   <= now_nxt;
      ex_r    <= ex_nxt;
      pos_r   <= pos_nxt;
      nret_r  <= nret_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Accepted operation and output payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tuser;
      ack_r <= SEQ_BITS'(in_tdata);
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_seq_r  <= SEQ_W'(e_seq);
      out_base_r <= SEQ_W'(base_nxt);
      out_fl_r   <= FL_W'(e_fl);
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DW - 2 * SEQ_W - FL_W)'(0), out_fl_r, out_base_r, out_seq_r};

endmodule
